/* hw/rtl/mol_pkg.sv */
// Package for the multichannel overdub looper: sizes, register indexes, helpers.
// No dependencies.
package mol_pkg;
  localparam int DefChannels   = 4;
  localparam int DefBufDepth   = 65536;
  localparam int SampleBits    = 24;
  localparam int IoBits        = 24;
  localparam int TimeBits      = 48;
  localparam int LenBits       = 40;
  localparam int CfgAddrBits   = 5;

  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_PLAY   = 3'd1;
  localparam logic [2:0] REG_SOLO   = 3'd2;
  localparam logic [2:0] REG_REC    = 3'd3;
  localparam logic [2:0] REG_BARS   = 3'd4;
  localparam logic [2:0] REG_RATE   = 3'd5;
  localparam logic [2:0] REG_TEMPO  = 3'd6;

  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } lane_cmd_t;
endpackage

/* hw/rtl/mol_divu.sv */
// Restoring divider, one quotient bit per cycle; returns quotient and remainder.
// Depends on mol_pkg.
module mol_divu import mol_pkg::*; #(
  parameter int NB = 48,
  parameter int DB = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic          done,
  output logic [NB-1:0] quo,
  output logic [DB-1:0] rem
);
  localparam int CB = $clog2(NB + 1);
  logic [NB-1:0] q_r, q_nxt;
  logic [DB:0]   r_r, r_nxt;
  logic [DB-1:0] d_r;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DB:0]   sh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {r_r[DB-1:0], q_r[NB-1]};
    if (start) begin
      q_nxt = num; r_nxt = '0; cnt_nxt = CB'(NB); busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[NB-2:0], 1'b0};
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r}; q_nxt[0] = 1'b1;
      end else begin
        r_nxt = sh;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt;
    if (start) d_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[DB-1:0];
endmodule

/* hw/rtl/mol_lane.sv */
// One loop channel: stereo sample memory with read, clear and saturating overdub.
// Depends on mol_pkg.
module mol_lane import mol_pkg::*; #(
  parameter int BUF_DEPTH = DefBufDepth
) (
  input  logic                          clk,
  input  lane_cmd_t                     cmd,
  input  logic [$clog2(BUF_DEPTH)-1:0]  addr,
  input  logic signed [SampleBits-1:0]  live_l,
  input  logic signed [SampleBits-1:0]  live_r,
  output logic signed [SampleBits-1:0]  rd_l,
  output logic signed [SampleBits-1:0]  rd_r
);
  localparam logic signed [SampleBits:0] SMax = (SampleBits+1)'((1 << (SampleBits-1)) - 1);
  localparam logic signed [SampleBits:0] SMin = -SMax - 1;
  logic signed [SampleBits-1:0] mem_l [BUF_DEPTH];
  logic signed [SampleBits-1:0] mem_r [BUF_DEPTH];
  logic signed [SampleBits:0] sl, sr;
  logic signed [SampleBits-1:0] wl, wr;

  always_comb begin
    sl = {rd_l[SampleBits-1], rd_l} + {live_l[SampleBits-1], live_l};
    sr = {rd_r[SampleBits-1], rd_r} + {live_r[SampleBits-1], live_r};
    wl = (sl > SMax) ? SMax[SampleBits-1:0] : (sl < SMin) ? SMin[SampleBits-1:0]
       : sl[SampleBits-1:0];
    wr = (sr > SMax) ? SMax[SampleBits-1:0] : (sr < SMin) ? SMin[SampleBits-1:0]
       : sr[SampleBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_l <= mem_l[addr];
      rd_r <= mem_r[addr];
    end
    if (cmd.wr) begin
      mem_l[addr] <= cmd.clr ? '0 : wl;
      mem_r[addr] <= cmd.clr ? '0 : wr;
    end
  end
endmodule

/* hw/rtl/mol_merge.sv */
// Merging stage: sums lane playback onto the live sample and saturates.
// Depends on mol_pkg.
module mol_merge import mol_pkg::*; #(
  parameter int CHANNELS = DefChannels
) (
  input  logic [CHANNELS-1:0]                  on,
  input  logic [CHANNELS-1:0][SampleBits-1:0]  lane_l,
  input  logic [CHANNELS-1:0][SampleBits-1:0]  lane_r,
  input  logic signed [IoBits-1:0]             live_l,
  input  logic signed [IoBits-1:0]             live_r,
  output logic signed [IoBits-1:0]             out_l,
  output logic signed [IoBits-1:0]             out_r
);
  localparam int W = SampleBits + 6;
  localparam logic signed [W-1:0] SMax = W'((64'sd1 <<< (SampleBits-1)) - 1);
  localparam logic signed [W-1:0] SMin = -SMax - 1;
  logic signed [W-1:0] al, ar, cl, cr;

  always_comb begin
    al = W'(live_l); ar = W'(live_r);
    for (int c = 0; c < CHANNELS; c++) begin
      if (on[c]) begin
        al = al + W'($signed(lane_l[c]));
        ar = ar + W'($signed(lane_r[c]));
      end
    end
    cl = (al > SMax) ? SMax : (al < SMin) ? SMin : al;
    cr = (ar > SMax) ? SMax : (ar < SMin) ? SMin : ar;
    out_l = IoBits'(cl);
    out_r = IoBits'(cr);
  end
endmodule

/* hw/rtl/multichannel_overdub_looper.sv */
// Multichannel overdub looper: control, clear sweep, lanes and merge.
// Depends on mol_pkg, mol_divu, mol_lane, mol_merge.
//
// Usage: stereo samples with their sample time enter on in_* (stream
// handshake); one result leaves on out_* per item. Registers are to be set
// over the cfg_* APB port only while idle; the block does not enforce this.
// Per item the loop length L = bars*rate*240/max(bpm,1) and the position
// sample_index mod L come from one shared bit-serial divider, one after
// the other; then a memory read state, an overdub state and output. Items
// are taken one at a time: the next is accepted only after the result is
// in the output register. With the looper off or a zero loop length the
// position division is skipped.
// Reset: registers take their reset values and a clearing pass writes zero
// to every memory position of every lane, with in_tready low.
// A stalled receiver holds the result in the output register; the next item
// is accepted meanwhile and waits before output only if still held.
module multichannel_overdub_looper import mol_pkg::*; #(
  parameter int CHANNELS    = DefChannels,
  parameter int BUF_DEPTH   = DefBufDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [95:0]            in_tdata,   // sample_index, left_in, right_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata,  // left_out, right_out
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CfgAddrBits-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  localparam int AB = $clog2(BUF_DEPTH);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_LEN, S_POS, S_RD, S_WR, S_OUT} state_t;
  state_t state_r, state_nxt;

  logic        act_r;
  logic [3:0]  play_r;
  logic [2:0]  solo_r, rec_r;
  logic [6:0]  bars_r;
  logic [17:0] rate_r;
  logic [9:0]  bpm_r;
  logic [AB-1:0] clr_r;
  logic [TimeBits-1:0] t_r;
  logic signed [IoBits-1:0] l_r, r_r;
  logic [AB-1:0] pos_r;
  logic hit_r;
  logic [IoBits-1:0] ol_r, or_r;
  logic ov_r;

  logic wr_en;
  logic [2:0] widx;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx  = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; play_r <= '0; solo_r <= 3'b111; rec_r <= 3'b111;
      bars_r <= 7'd1; rate_r <= 18'd44100; bpm_r <= 10'd120;
    end else if (wr_en) begin
      case (widx)
        REG_ACTIVE: act_r  <= cfg_pwdata[0];
        REG_PLAY:   play_r <= cfg_pwdata[3:0];
        REG_SOLO:   solo_r <= cfg_pwdata[2:0];
        REG_REC:    rec_r  <= cfg_pwdata[2:0];
        REG_BARS:   bars_r <= cfg_pwdata[6:0];
        REG_RATE:   rate_r <= cfg_pwdata[17:0];
        REG_TEMPO:  bpm_r  <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_ACTIVE: cfg_prdata = {31'd0, act_r};
      REG_PLAY:   cfg_prdata = {28'd0, play_r};
      REG_SOLO:   cfg_prdata = {29'd0, solo_r};
      REG_REC:    cfg_prdata = {29'd0, rec_r};
      REG_BARS:   cfg_prdata = {25'd0, bars_r};
      REG_RATE:   cfg_prdata = {14'd0, rate_r};
      REG_TEMPO:  cfg_prdata = {22'd0, bpm_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // loop length numerator: bars*rate*240 = bars*rate*(256-16), up to 33 bits
  logic [24:0]        bars_rate;
  logic [LenBits-1:0] prod;
  logic [9:0]         bpm_eff;
  assign bars_rate = 25'(bars_r) * 25'(rate_r);
  assign prod      = (LenBits'(bars_rate) << 8) - (LenBits'(bars_rate) << 4);
  assign bpm_eff   = (bpm_r == '0) ? 10'd1 : bpm_r;

  logic div_start, div_done;
  logic [TimeBits-1:0] div_num, div_q;
  logic [LenBits-1:0]  div_den, div_rem;
  always_comb begin
    div_num = (state_r == S_IDLE) ? TimeBits'(prod) : t_r;
    div_den = (state_r == S_IDLE) ? LenBits'(bpm_eff) : div_q[LenBits-1:0];
  end

  mol_divu #(.NB(TimeBits), .DB(LenBits)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .rem(div_rem)
  );

  logic in_acc, out_acc;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {or_r, ol_r};

  logic [CHANNELS-1:0] on, recv;
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      recv[c] = hit_r && !rec_r[2] && (rec_r[1:0] == 2'(c)) && (c < 4);
      on[c]   = hit_r && (c < 4) && play_r[c % 4]
                && (solo_r[2] || (solo_r[1:0] == 2'(c)));
    end
  end

  logic [CHANNELS-1:0][SampleBits-1:0] lane_l, lane_r;
  logic [IoBits-1:0] ml, mr;
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    lane_cmd_t cmd;
    logic [AB-1:0] addr;
    logic signed [SampleBits-1:0] lv_l, lv_r, rl, rr;
    always_comb begin
      cmd.clr = (state_r == S_CLR);
      cmd.rd  = (state_r == S_RD) && hit_r;
      cmd.wr  = (state_r == S_CLR) || ((state_r == S_WR) && recv[g]);
      addr    = (state_r == S_CLR) ? clr_r : pos_r;
      lv_l    = SampleBits'(l_r);
      lv_r    = SampleBits'(r_r);
    end
    mol_lane #(.BUF_DEPTH(BUF_DEPTH)) u_lane (
      .clk, .cmd, .addr,
      .live_l((state_r == S_CLR) ? '0 : lv_l), .live_r((state_r == S_CLR) ? '0 : lv_r),
      .rd_l(rl), .rd_r(rr)
    );
    assign lane_l[g] = (state_r == S_CLR) ? '0 : rl;
    assign lane_r[g] = (state_r == S_CLR) ? '0 : rr;
  end

  mol_merge #(.CHANNELS(CHANNELS)) u_merge (
    .on, .lane_l, .lane_r, .live_l(l_r), .live_r(r_r), .out_l(ml), .out_r(mr)
  );

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      S_CLR:  if (clr_r == AB'(BUF_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_acc) begin
        div_start = 1'b1; state_nxt = S_LEN;
      end
      S_LEN:  if (div_done) begin
        if (act_r && div_q[LenBits-1:0] != '0) begin
          div_start = 1'b1; state_nxt = S_POS;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_POS:  if (div_done) state_nxt = S_RD;
      S_RD:   state_nxt = S_WR;
      S_WR:   state_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // the clear sweep writes zero to every position of every lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; ov_r <= 1'b0; hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_IDLE && in_acc) hit_r <= 1'b0;
      if (state_r == S_POS && div_done)
        hit_r <= (div_rem < LenBits'(BUF_DEPTH));
      if (state_r == S_OUT && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_acc) ov_r <= 1'b0;
    end
    if (in_acc) begin
      t_r <= in_tdata[47:0]; l_r <= in_tdata[71:48]; r_r <= in_tdata[95:72];
    end
    if (state_r == S_POS && div_done) pos_r <= div_rem[AB-1:0];
    if (state_r == S_OUT && (!ov_r || out_tready)) begin
      ol_r <= ml; or_r <= mr;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && hit_r) |-> $countones(recv) <= 1)
    else $error("overdub to more than one channel");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ($stable(ol_r) && $stable(or_r)))
    else $error("held result changed");
endmodule

/* bench/multichannel_overdub_looper_test.sv */
// Testbench for multichannel_overdub_looper: stream items in, one result per item out.
// Predicts loop playback and overdub with its own copy of the stores and registers.
// Depends on mol_pkg and the looper RTL.
`timescale 1ns / 100ps
module multichannel_overdub_looper_test import mol_pkg::*; ;

  localparam int NCH = DefChannels;
  localparam int DEPTH = DefBufDepth;
  localparam logic signed [24:0] SMAX = 25'sd8388607;
  localparam logic signed [24:0] SMIN = -25'sd8388608;

  typedef struct {
    logic [47:0] t;
    logic [23:0] l;
    logic [23:0] r;
  } sample_t;

  typedef struct {
    logic [23:0] l;
    logic [23:0] r;
  } mix_t;

  typedef struct {
    sample_t s;
    bit      known;
    mix_t    m;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [95:0] in_tdata;
  logic [47:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CfgAddrBits-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  multichannel_overdub_looper dut (.*);

  logic signed [23:0] left_mem [NCH*DEPTH];
  logic signed [23:0] right_mem [NCH*DEPTH];
  logic        r_active;
  logic [3:0]  r_play;
  logic [2:0]  r_solo, r_rec;
  logic [6:0]  r_bars;
  logic [17:0] r_rate;
  logic [9:0]  r_tempo;

  mix_t mix_q[$];
  int   errors = 0;
  int   send_idle = 0, recv_idle = 0;
  bit   hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("** multichannel_overdub_looper: FAILED **");
    $finish;
  end

  function automatic logic [23:0] clamp(logic signed [24:0] v);
    if (v > SMAX) return SMAX[23:0];
    if (v < SMIN) return SMIN[23:0];
    return v[23:0];
  endfunction

  function automatic logic [63:0] loop_len();
    logic [63:0] bpm;
    bpm = (r_tempo == 0) ? 64'd1 : 64'(r_tempo);
    return 64'(r_bars) * 64'(r_rate) * 64'd240 / bpm;
  endfunction

  function automatic mix_t mix_sample(sample_t s);
    mix_t m;
    logic [63:0] len, pos;
    logic signed [31:0] lo, ro;
    logic signed [2:0] solo, rec;
    int a;
    lo = 32'(signed'(s.l));
    ro = 32'(signed'(s.r));
    len = loop_len();
    if (r_active && len != 0) begin
      pos = 64'(s.t) % len;
      if (pos < DEPTH) begin
        solo = signed'(r_solo);
        rec = signed'(r_rec);
        for (int c = 0; c < NCH; c++) begin
          if (r_play[c] && (solo < 0 || c == solo)) begin
            a = c * DEPTH + int'(pos);
            lo += 32'(left_mem[a]);
            ro += 32'(right_mem[a]);
          end
        end
        if (rec >= 0 && rec < NCH) begin
          a = int'(rec) * DEPTH + int'(pos);
          left_mem[a] = clamp(25'(left_mem[a]) + 25'(signed'(s.l)));
          right_mem[a] = clamp(25'(right_mem[a]) + 25'(signed'(s.r)));
        end
      end
    end
    m.l = (lo > SMAX) ? SMAX[23:0] : (lo < SMIN) ? SMIN[23:0] : lo[23:0];
    m.r = (ro > SMAX) ? SMAX[23:0] : (ro < SMIN) ? SMIN[23:0] : ro[23:0];
    return m;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= CfgAddrBits'({idx, 2'b00}); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      REG_ACTIVE: r_active = val[0];
      REG_PLAY:   r_play = val[3:0];
      REG_SOLO:   r_solo = val[2:0];
      REG_REC:    r_rec = val[2:0];
      REG_BARS:   r_bars = val[6:0];
      REG_RATE:   r_rate = val[17:0];
      REG_TEMPO:  r_tempo = val[9:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (mix_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_sample(sample_t s, bit known, mix_t m);
    mix_t p;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tdata <= {s.r, s.l, s.t};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    p = mix_sample(s);
    if (known && p.l != m.l) begin
      $error("left_out table %h predictor %h", m.l, p.l);
      errors++;
    end
    if (known && p.r != m.r) begin
      $error("right_out table %h predictor %h", m.r, p.r);
      errors++;
    end
    mix_q.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(64)) - 24'd32;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_time(int span);
    logic [47:0] t;
    if ($urandom_range(15) == 0) t = 48'({$urandom, $urandom});
    else t = 48'($urandom_range(span - 1));
    return t;
  endfunction

  task automatic random_phase(int n, int span);
    sample_t s;
    mix_t z;
    z = '{0, 0};
    for (int i = 0; i < n; i++) begin
      s.t = rand_time(span);
      s.l = rand_sample();
      s.r = rand_sample();
      send_sample(s, 0, z);
    end
  endtask

  // receiver
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    mix_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (mix_q.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        e = mix_q.pop_front();
        if (out_tdata[23:0] !== e.l) begin
          $error("left_out expected %h actual %h", e.l, out_tdata[23:0]);
          errors++;
        end
        if (out_tdata[47:24] !== e.r) begin
          $error("right_out expected %h actual %h", e.r, out_tdata[47:24]);
          errors++;
        end
      end
    end
  end

  row_t rows[$];

  initial begin
    sample_t s;
    mix_t z;
    z = '{0, 0};
    rst_n = 0; in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    foreach (left_mem[i]) begin
      left_mem[i] = 0;
      right_mem[i] = 0;
    end
    r_active = 0; r_play = 0; r_solo = 3'b111; r_rec = 3'b111;
    r_bars = 1; r_rate = 44100; r_tempo = 120;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // pass-through after reset: output equals input
    rows.push_back('{'{48'hFFFF_FFFF_FFFF, 24'h7FFFFF, 24'h800000}, 1, '{24'h7FFFFF, 24'h800000}});
    rows.push_back('{'{48'd0, 24'h800000, 24'h7FFFFF}, 1, '{24'h800000, 24'h7FFFFF}});
    rows.push_back('{'{48'd12345, 24'h000001, 24'hFFFFFF}, 1, '{24'h000001, 24'hFFFFFF}});
    foreach (rows[i]) send_sample(rows[i].s, rows[i].known, rows[i].m);
    drain();

    // record channel 0 then play, saturating overdub
    reg_write(REG_ACTIVE, 1); reg_write(REG_PLAY, 15);
    reg_write(REG_REC, 0); reg_write(REG_SOLO, 7);
    reg_write(REG_BARS, 1); reg_write(REG_RATE, 8000); reg_write(REG_TEMPO, 0);
    rows.delete();
    rows.push_back('{'{48'd5, 24'h7FFFFF, 24'h800000}, 0, z});
    rows.push_back('{'{48'd5, 24'h7FFFFF, 24'h800000}, 0, z});
    rows.push_back('{'{48'd5, 24'h000010, 24'h000010}, 0, z});
    rows.push_back('{'{48'd65535, 24'h123456, 24'hABCDEF}, 0, z});
    rows.push_back('{'{48'd65536, 24'h111111, 24'h222222}, 0, z});
    rows.push_back('{'{48'd1920000 + 5, 24'h000001, 24'h000002}, 0, z});
    rows.push_back('{'{48'hFFFF_FFFF_FFFF, 24'h400000, 24'hC00000}, 0, z});
    foreach (rows[i]) send_sample(rows[i].s, rows[i].known, rows[i].m);
    drain();
    // solo, select beyond channels, zero length, largest bars and rate
    reg_write(REG_SOLO, 0); reg_write(REG_REC, 4);
    s = '{48'd5, 24'h000001, 24'h000001}; send_sample(s, 0, z);
    drain();
    reg_write(REG_SOLO, 3); reg_write(REG_REC, 3);
    send_sample(s, 0, z);
    drain();
    reg_write(REG_BARS, 0);
    send_sample(s, 0, z);
    drain();
    reg_write(REG_BARS, 127); reg_write(REG_RATE, 32'h3FFFF); reg_write(REG_TEMPO, 999);
    send_sample(s, 0, z);
    drain();
    reg_write(REG_BARS, 1); reg_write(REG_RATE, 0);
    send_sample(s, 0, z);
    drain();

    // random phases
    send_idle = 29; recv_idle = 79;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 79; recv_idle = 29; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      reg_write(REG_ACTIVE, 32'($urandom_range(7) != 0));
      reg_write(REG_PLAY, $urandom_range(15));
      reg_write(REG_SOLO, $urandom_range(3) == 0 ? $urandom_range(7) : 32'd7);
      reg_write(REG_REC, $urandom_range(7));
      reg_write(REG_BARS, ph == 5 ? 64 : $urandom_range(1, 4));
      reg_write(REG_RATE, ph == 1 ? 192000 : $urandom_range(8000, 48000));
      reg_write(REG_TEMPO, ph == 3 ? 1 : $urandom_range(60, 999));
      if (ph == 4) begin
        hold_off = 1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      random_phase(180, 300);
      drain();
    end
    if (errors == 0 && mix_q.size() == 0)
      $display("** multichannel_overdub_looper: PASSED **");
    else
      $display("** multichannel_overdub_looper: FAILED **");
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/mol_pkg.sv
hw/rtl/mol_divu.sv
hw/rtl/mol_lane.sv
hw/rtl/mol_merge.sv
hw/rtl/multichannel_overdub_looper.sv
bench/multichannel_overdub_looper_test.sv
